// ===== sv/sem_pkg.sv =====
// Shared types and constants for the RGB Sobel edge magnitude unit.
// No dependencies; imported by the controller, datapath and top level.
package sem_pkg;

    // one color component and one RGB pixel ([2] red, [1] green, [0] blue)
    typedef logic [7:0]       chan_t;
    typedef logic [2:0][7:0]  pixel_t;

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    // row counters saturate at all ones
    localparam int ROW_W = 16;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam int CFG_DATA_W   = 13;
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // gradient and magnitude widths
    localparam int GRAD_W = 11;                 // |gx|,|gy| <= 1020
    localparam int SUMSQ_W = 21;                // gx^2 + gy^2 <= 2080800
    localparam int RAD_W = 16;
    // above 255^2 + 255 the rounded root exceeds 255
    localparam logic [SUMSQ_W-1:0] SAT_LIMIT = 21'd65280;
    localparam int ROOT_STEPS = 8;
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd7;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd0;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SQUARE,
        S_ROOT,
        S_FINISH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic              accept;   // latch input beat, read line stores
        logic              load;     // shift window, write line stores, count
        logic              square;   // form gx^2 + gy^2
        logic              root;     // one square root step
        logic [STEP_W-1:0] step;     // root step index, high to low
        logic              finish;   // round and fill the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;       // current item produces a result
        logic out_free;   // output register can take a result
    } status_t;

endpackage

// ===== sv/sem_ctrl.sv =====
// Controller state machine for the RGB Sobel edge magnitude unit.
// Depends on sem_pkg; drives sem_dp through cmd_t and reads status_t.
module sem_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  sem_pkg::status_t status,
    output sem_pkg::cmd_t    cmd
);
    import sem_pkg::*;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (status.emit)
                    state_next = S_SQUARE;
                else
                    state_next = S_IDLE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                step_next  = STEP_FIRST;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root = 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_FINISH;
                else
                    step_next = step_reg - STEP_W'(1);
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sem_dp.sv =====
// Datapath of the RGB Sobel edge magnitude unit: line stores, 3x3 window,
// position counters, gradients, square root and output register. Uses sem_pkg.
module sem_dp #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int W_W       = $clog2(MAX_WIDTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sem_pkg::cmd_t                 cmd,
    output sem_pkg::status_t              status,
    input  logic                          kind,
    input  sem_pkg::chan_t                red_in,
    input  sem_pkg::chan_t                green_in,
    input  sem_pkg::chan_t                blue_in,
    input  logic [W_W-1:0]                width_use,
    input  logic [sem_pkg::IMG_HEIGHT_W-1:0] height_use,
    input  logic                          out_stall,
    output logic                          out_valid,
    output sem_pkg::chan_t                red_out,
    output sem_pkg::chan_t                green_out,
    output sem_pkg::chan_t                blue_out,
    output logic                          frame_end
);
    import sem_pkg::*;

    // line stores: line_b holds the previous row, line_a the one before
    pixel_t line_a_mem [MAX_WIDTH];
    pixel_t line_b_mem [MAX_WIDTH];
    pixel_t rd_a_reg;
    pixel_t rd_b_reg;
    pixel_t pix_reg;
    logic [COL_W-1:0] addr_reg;
    logic [COL_W-1:0] rd_addr;

    // window and positions
    pixel_t            win_reg  [3][3];
    pixel_t            win_next [3][3];
    pixel_t            shifted  [3][3];
    pixel_t            masked   [3][3];
    pixel_t            new_col  [3];
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic              col_zero;
    logic              in_row_end;
    logic              out_row_end;
    logic              top_mask;
    logic              bot_mask;
    logic              emit;
    logic              last;

    // arithmetic
    logic signed [GRAD_W-1:0] gx_reg [3];
    logic signed [GRAD_W-1:0] gy_reg [3];
    logic                     last_reg;
    logic                     sat_reg [3];
    logic [RAD_W-1:0]         rem_reg [3];
    logic [RAD_W-1:0]         res_reg [3];
    logic [RAD_W-1:0]         root_bit;

    // output register
    logic   out_valid_reg;
    pixel_t out_pix_reg;
    logic   frame_end_reg;

    // (a0 + 2 a1 + a2) - (b0 + 2 b1 + b2)
    function automatic logic signed [GRAD_W-1:0] sobel_diff(
        input chan_t a0, input chan_t a1, input chan_t a2,
        input chan_t b0, input chan_t b1, input chan_t b2);
        logic [GRAD_W-2:0] pos;
        logic [GRAD_W-2:0] neg;
        pos = (GRAD_W-1)'(a0) + {1'b0, a1, 1'b0} + (GRAD_W-1)'(a2);
        neg = (GRAD_W-1)'(b0) + {1'b0, b1, 1'b0} + (GRAD_W-1)'(b2);
        return $signed({1'b0, pos}) - $signed({1'b0, neg});
    endfunction

    // line store address: column clamped to the width in use
    assign rd_addr = (W_W'(in_col_reg) < width_use) ? in_col_reg
                                                     : COL_W'(width_use - W_W'(1));

    // line stores and input latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_a_reg <= line_a_mem[rd_addr];
            rd_b_reg <= line_b_mem[rd_addr];
            addr_reg <= rd_addr;
            pix_reg  <= kind ? pixel_t'(0) : {red_in, green_in, blue_in};
        end
        if (cmd.load)
        begin
            line_a_mem[addr_reg] <= rd_b_reg;
            line_b_mem[addr_reg] <= pix_reg;
        end
    end

    // window shift, row masking and position update
    always_comb
    begin
        col_zero    = (in_col_reg == '0);
        in_row_end  = (W_W'(in_col_reg) + W_W'(1)) >= width_use;
        out_row_end = (W_W'(out_col_reg) + W_W'(1)) >= width_use;
        top_mask    = (out_row_reg == '0);
        bot_mask    = ({1'b0, out_row_reg} + (ROW_W+1)'(1)) >= (ROW_W+1)'(height_use);
        emit        = (in_row_reg >= ROW_W'(2))
                      || ((in_row_reg == ROW_W'(1)) && !col_zero);
        last        = emit && bot_mask && out_row_end;

        new_col[0] = rd_a_reg;
        new_col[1] = rd_b_reg;
        new_col[2] = pix_reg;

        for (int r = 0; r < 3; r++)
        begin
            shifted[r][0] = win_reg[r][1];
            shifted[r][1] = win_reg[r][2];
            shifted[r][2] = col_zero ? pixel_t'(0) : new_col[r];
            for (int c = 0; c < 3; c++)
            begin
                masked[r][c] = shifted[r][c];
                if ((r == 0 && top_mask) || (r == 2 && bot_mask))
                    masked[r][c] = '0;
                if (last)
                    win_next[r][c] = '0;
                else if (col_zero)
                    win_next[r][c] = (c == 2) ? new_col[r] : pixel_t'(0);
                else
                    win_next[r][c] = shifted[r][c];
            end
        end

        // input position
        in_col_next = in_col_reg + COL_W'(1);
        in_row_next = in_row_reg;
        if (in_row_end)
        begin
            in_col_next = '0;
            if (in_row_reg != '1)
                in_row_next = in_row_reg + ROW_W'(1);
        end

        // output position
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit)
        begin
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (out_row_end)
            begin
                out_col_next = '0;
                if (out_row_reg != '1)
                    out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    // control registers of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (cmd.load)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            win_reg     <= win_next;
        end
    end

    // root step weight: 4^step
    assign root_bit = RAD_W'(RAD_W'(1) << {cmd.step, 1'b0});

    // gradients, sum of squares and square root, one unit per channel
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            last_reg <= last;
        for (int ch = 0; ch < 3; ch++)
        begin
            logic signed [2*GRAD_W-1:0] sqx;
            logic signed [2*GRAD_W-1:0] sqy;
            logic [SUMSQ_W-1:0]         sumsq;
            logic [RAD_W:0]             trial;
            sqx   = gx_reg[ch] * gx_reg[ch];
            sqy   = gy_reg[ch] * gy_reg[ch];
            sumsq = sqx[SUMSQ_W-1:0] + sqy[SUMSQ_W-1:0];
            trial = {1'b0, res_reg[ch]} + {1'b0, root_bit};
            if (cmd.load)
            begin
                gx_reg[ch] <= sobel_diff(masked[0][2][ch], masked[1][2][ch],
                                         masked[2][2][ch], masked[0][0][ch],
                                         masked[1][0][ch], masked[2][0][ch]);
                gy_reg[ch] <= sobel_diff(masked[2][0][ch], masked[2][1][ch],
                                         masked[2][2][ch], masked[0][0][ch],
                                         masked[0][1][ch], masked[0][2][ch]);
            end
            if (cmd.square)
            begin
                sat_reg[ch] <= sumsq > SAT_LIMIT;
                rem_reg[ch] <= sumsq[RAD_W-1:0];
                res_reg[ch] <= '0;
            end
            else if (cmd.root)
            begin
                if ({1'b0, rem_reg[ch]} >= trial)
                begin
                    rem_reg[ch] <= RAD_W'({1'b0, rem_reg[ch]} - trial);
                    res_reg[ch] <= (res_reg[ch] >> 1) + root_bit;
                end
                else
                begin
                    res_reg[ch] <= res_reg[ch] >> 1;
                end
            end
        end
    end

    // output register: round to nearest, saturate at 255
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            frame_end_reg <= last_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                if (sat_reg[ch])
                    out_pix_reg[ch] <= 8'hFF;
                else
                    out_pix_reg[ch] <= res_reg[ch][7:0]
                                       + 8'(rem_reg[ch] > res_reg[ch]);
            end
        end
    end

    assign status.emit     = emit;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg[CH_RED];
    assign green_out = out_pix_reg[CH_GREEN];
    assign blue_out  = out_pix_reg[CH_BLUE];
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/sobel_edge_magnitude_rgb_unit.sv =====
// RGB 3x3 Sobel edge magnitude, raster-order stream with valid/stall beats.
// One item in flight: an accepted beat goes through load, square, 8 root steps
// and finish (held while a stalled result blocks the output register); its result
// shows as the input reopens. A beat with no result goes through load only.
// Reset (async, active low) clears control, counters, window and config
// registers to 640x480; the line stores are not cleared.
module sobel_edge_magnitude_rgb_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        red_out,
    output logic [7:0]                        green_out,
    output logic [7:0]                        blue_out,
    output logic                              frame_end,
    input  logic                              cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (W_W > IMG_WIDTH_W) ? W_W : IMG_WIDTH_W;

    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic [W_W-1:0]          width_use;
    logic [IMG_HEIGHT_W-1:0] height_use;
    cmd_t                    cmd;
    status_t                 status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // width clamped to 1..MAX_WIDTH, height at least 1
    always_comb
    begin
        if (width_reg == '0)
            width_use = W_W'(1);
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
            width_use = W_W'(MAX_WIDTH);
        else
            width_use = W_W'(width_reg);
        height_use = (height_reg == '0) ? IMG_HEIGHT_W'(1) : height_reg;
    end

    sem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sem_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .W_W       (W_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .kind       (kind),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .width_use  (width_use),
        .height_use (height_use),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_end  (frame_end)
    );

endmodule

// ===== sv/sem_checker.sv =====
// Port-level checks for the RGB Sobel edge magnitude unit.
// Bound to sobel_edge_magnitude_rgb_unit; needs no package.
module sem_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic       frame_end
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out) && $stable(frame_end))
    else $error("stalled output beat changed");

    // one item at a time: an accepted beat closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input open right after an accepted beat");

    // a new result only comes from an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in flight");

    // an accepted beat cannot produce a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early after acceptance");

endmodule

bind sobel_edge_magnitude_rgb_unit sem_checker u_sem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
);

// ===== tb/sobel_mag_monitor.sv =====
// Stream monitor for the RGB Sobel edge magnitude unit: tracks register writes,
// predicts every result beat from the accepted input beats and compares them.
// Depends on sem_pkg for pixel types, config indexes and reset geometry.
module sobel_mag_monitor #(
    parameter int MAX_W = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           kind,
    input  logic [7:0]                     red_in,
    input  logic [7:0]                     green_in,
    input  logic [7:0]                     blue_in,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     red_out,
    input  logic [7:0]                     green_out,
    input  logic [7:0]                     blue_out,
    input  logic                           frame_end,
    input  logic                           cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             results_seen,
    output logic                           at_frame_start
);
    timeunit 1ns;
    timeprecision 1ps;
    import sem_pkg::*;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  frame_last;
    } magnitude_beat_t;

    // predicted result beats, oldest first
    magnitude_beat_t magnitude_q [$];

    // shadow of the block's geometry registers and stream state
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    pixel_t                  row_mem [2*MAX_W];
    pixel_t                  win [9];
    logic [IMG_WIDTH_W-1:0]  in_col;
    logic [IMG_WIDTH_W-1:0]  out_col;
    logic [ROW_W-1:0]        in_row;
    logic [ROW_W-1:0]        out_row;

    assign at_frame_start = (in_col == 0) && (in_row == 0);

    initial begin
        for (int i = 0; i < 2*MAX_W; i++) row_mem[i] = '0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // rounded square root, bit by bit, clipped to one channel
    function automatic chan_t rounded_root(input int unsigned s);
        int unsigned n;
        int unsigned trial;
        n = 0;
        for (int b = 10; b >= 0; b--) begin
            trial = n | (32'd1 << b);
            if (trial * trial <= s) n = trial;
        end
        if (s > n * n + n) n++;
        return (n > 255) ? 8'hFF : n[7:0];
    endfunction

    // window moves left by one column; new column enters on the right
    task automatic shift_column(input pixel_t upper, input pixel_t middle, input pixel_t lower);
        for (int r = 0; r < 3; r++) begin
            win[3*r]   = win[3*r+1];
            win[3*r+1] = win[3*r+2];
        end
        win[2] = upper;
        win[5] = middle;
        win[8] = lower;
    endtask

    // one accepted input beat: update line memory and window, queue any result
    task automatic advance_stream(input logic is_drain, input pixel_t pix);
        int unsigned     w;
        int unsigned     h;
        int unsigned     col;
        pixel_t          cur;
        pixel_t          above2;
        pixel_t          above1;
        pixel_t          m [9];
        pixel_t          mag;
        int              p [9];
        int              gx;
        int              gy;
        logic            emit;
        logic            frame_done;
        magnitude_beat_t res;

        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        col = (in_col < w) ? in_col : w - 1;
        cur = is_drain ? '0 : pix;

        above2 = row_mem[MAX_W + col];
        above1 = row_mem[col];
        row_mem[MAX_W + col] = above1;
        row_mem[col] = cur;

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        frame_done = 1'b0;

        if (in_col == 0) shift_column('0, '0, '0);
        else shift_column(above2, above1, cur);

        if (emit) begin
            m = win;
            // rows outside the image read as zero
            if (out_row < 1) begin
                m[0] = '0; m[1] = '0; m[2] = '0;
            end
            if (out_row + 1 >= h) begin
                m[6] = '0; m[7] = '0; m[8] = '0;
            end
            frame_done = (out_row + 1 >= h) && (out_col + 1 >= w);
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 9; i++) p[i] = m[i][ch];
                gx = (p[2] + 2*p[5] + p[8]) - (p[0] + 2*p[3] + p[6]);
                gy = (p[6] + 2*p[7] + p[8]) - (p[0] + 2*p[1] + p[2]);
                mag[ch] = rounded_root(gx*gx + gy*gy);
            end
            res.red        = mag[CH_RED];
            res.green      = mag[CH_GREEN];
            res.blue       = mag[CH_BLUE];
            res.frame_last = frame_done;
            magnitude_q.push_back(res);
        end

        // a new row starts from a cleared window
        if (in_col == 0) begin
            win = '{default: '0};
            shift_column(above2, above1, cur);
        end

        if (in_col + 1 >= w) begin
            in_col = '0;
            if (in_row != {ROW_W{1'b1}}) in_row++;
        end else begin
            in_col++;
        end

        if (emit) begin
            if (frame_done) begin
                in_col  = '0;
                in_row  = '0;
                out_col = '0;
                out_row = '0;
                win = '{default: '0};
            end else if (out_col + 1 >= w) begin
                out_col = '0;
                if (out_row != {ROW_W{1'b1}}) out_row++;
            end else begin
                out_col++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        magnitude_beat_t want;
        if (!rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            win = '{default: '0};
            in_col  = '0;
            in_row  = '0;
            out_col = '0;
            out_row = '0;
            magnitude_q.delete();
            mismatches   = 0;
            results_seen = 0;
            pending      = 0;
        end else begin
            // result beat against the oldest prediction
            if (out_valid && !out_stall) begin
                if (magnitude_q.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d (%0d,%0d,%0d,%0d) with none predicted",
                                              results_seen, red_out, green_out, blue_out, frame_end));
                end else begin
                    want = magnitude_q.pop_front();
                    if (red_out !== want.red)
                        report_mismatch($sformatf("beat %0d red %0d, predicted %0d",
                                                  results_seen, red_out, want.red));
                    if (green_out !== want.green)
                        report_mismatch($sformatf("beat %0d green %0d, predicted %0d",
                                                  results_seen, green_out, want.green));
                    if (blue_out !== want.blue)
                        report_mismatch($sformatf("beat %0d blue %0d, predicted %0d",
                                                  results_seen, blue_out, want.blue));
                    if (frame_end !== want.frame_last)
                        report_mismatch($sformatf("beat %0d frame_end %0b, predicted %0b",
                                                  results_seen, frame_end, want.frame_last));
                end
                results_seen++;
            end

            if (in_valid && !in_stall)
                advance_stream(kind, {red_in, green_in, blue_in});

            if (cfg_write) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_data[IMG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            pending = magnitude_q.size();
        end
    end

endmodule

// ===== tb/sobel_edge_magnitude_rgb_unit_tb.sv =====
// Top of the Sobel edge magnitude testbench: clock, reset, stimulus and verdict.
// Depends on sem_pkg, the sobel_edge_magnitude_rgb_unit RTL and sobel_mag_monitor.
module sobel_edge_magnitude_rgb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sem_pkg::*;

    localparam int   MAX_WIDTH     = 1024;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   TAIL_CYCLES   = 30;
    localparam int   PHASE_BEATS   = 70;
    localparam logic ITEM_PIXEL    = 1'b0;
    localparam logic ITEM_DRAIN    = 1'b1;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [7:0]            red_in;
    logic [7:0]            green_in;
    logic [7:0]            blue_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            red_out;
    logic [7:0]            green_out;
    logic [7:0]            blue_out;
    logic                  frame_end;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   mismatches;
    int   pending;
    int   results_seen;
    logic at_origin;

    int src_idle_pct;
    int sink_stall_pct;
    int beats_sent;
    int frames_sent;

    sobel_edge_magnitude_rgb_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sobel_mag_monitor #(
        .MAX_W (MAX_WIDTH)
    ) monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .frame_end      (frame_end),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen),
        .at_frame_start (at_origin)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver back-pressure
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // run limit
    initial begin
        #(20_000_000);
        $display("watchdog expired, %0d results still outstanding", pending);
        $display("sobel_edge_magnitude_rgb_unit_tb NOT OK");
        $finish;
    end

    // mostly random values, with full-scale extremes mixed in
    function automatic chan_t rand_chan();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return chan_t'($urandom_range(255));
    endfunction

    function automatic pixel_t rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic push_beat(input logic k, input pixel_t px);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        red_in   <= px[CH_RED];
        green_in <= px[CH_GREEN];
        blue_in  <= px[CH_BLUE];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // hold off until every predicted result is out and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) push_beat(ITEM_PIXEL, rand_pixel());
    endtask

    // flush beats until the frame wraps; some may be stray pixels
    task automatic close_frame(input int pixel_pct);
        while (!at_origin)
            push_beat(($urandom_range(99) < pixel_pct) ? ITEM_PIXEL : ITEM_DRAIN, rand_pixel());
        frames_sent++;
    endtask

    // small random frame: mostly clean raster, sometimes mixed beats and a resize
    task automatic run_random_frame();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        logic        noisy;
        w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        h = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
        n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        noisy = ($urandom_range(3) == 0);
        settle();
        set_geometry(w, h);
        if (!noisy) begin
            send_pixels(n);
            close_frame(5);
        end else begin
            repeat ($urandom_range(1, n))
                push_beat(($urandom_range(3) == 0) ? ITEM_DRAIN : ITEM_PIXEL, rand_pixel());
            if ($urandom_range(1) == 1) begin
                settle();
                set_geometry($urandom_range(0, 8), $urandom_range(0, 6));
            end
            close_frame(30);
        end
    endtask

    initial begin
        pixel_t px;
        int     phase_mark;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = ITEM_PIXEL;
        red_in         = '0;
        green_in       = '0;
        blue_in        = '0;
        out_stall      = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_IMAGE_WIDTH;
        cfg_data       = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        beats_sent     = 0;
        frames_sent    = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // width register over the limit, then shrunk: line index gets clamped
        settle();
        set_geometry(2047, 3);
        send_pixels(6);
        settle();
        set_geometry(3, 3);
        close_frame(0);

        // zero width and zero height both behave as one
        settle();
        set_geometry(0, 0);
        push_beat(ITEM_PIXEL, {3{8'hFF}});
        close_frame(0);

        // 3x3 checkerboard drives gradients to saturation; drain beat inside
        // the image, then a stray pixel in the flush
        settle();
        set_geometry(3, 3);
        for (int i = 0; i < 9; i++) begin
            px[CH_RED]   = (((i / 3) + (i % 3)) % 2 == 1) ? 8'hFF : 8'h00;
            px[CH_GREEN] = ~px[CH_RED];
            px[CH_BLUE]  = (i % 3 == 2) ? 8'hFF : 8'h00;
            push_beat((i == 4) ? ITEM_DRAIN : ITEM_PIXEL, px);
        end
        push_beat(ITEM_PIXEL, {3{8'hFF}});
        close_frame(0);

        // shrink mid-frame: column index past the new width gets clamped
        settle();
        set_geometry(4, 3);
        send_pixels(7);
        settle();
        set_geometry(2, 2);
        close_frame(0);

        // grow mid-frame
        settle();
        set_geometry(2, 4);
        send_pixels(3);
        settle();
        set_geometry(5, 6);
        close_frame(0);

        // tallest height register on a single column, cut short mid-frame
        settle();
        set_geometry(1, 8191);
        send_pixels(12);
        settle();
        set_geometry(1, 12);
        close_frame(0);

        // random frames under four pacing mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            phase_mark = beats_sent;
            while (beats_sent - phase_mark < PHASE_BEATS) run_random_frame();
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d input beats over %0d frames, %0d result beats checked",
                 beats_sent, frames_sent, results_seen);
        $display("frames from 1x1 up, over-limit width and 8191-row height, resizes mid-frame, four pacing mixes");
        if (mismatches == 0 && pending == 0)
            $display("sobel_edge_magnitude_rgb_unit_tb OK");
        else
            $display("sobel_edge_magnitude_rgb_unit_tb NOT OK");
        $finish;
    end

endmodule
